>>> rtl/core/thrq_pkg.sv
// shared types and constants for the timestamped history ring query core
// no dependencies
package thrq_pkg;

  localparam logic [0:0] KindAppend = 1'b0;
  localparam logic [0:0] KindQuery  = 1'b1;

  localparam logic [2:0] ModeLatest      = 3'd0;
  localparam logic [2:0] ModeLatestAfter = 3'd1;
  localparam logic [2:0] ModeBefore      = 3'd2;
  localparam logic [2:0] ModeAfter       = 3'd3;
  localparam logic [2:0] ModeAround      = 3'd4;
  localparam logic [2:0] ModeBetween     = 3'd5;

  localparam logic [0:0] CfgMaxLimit = 1'b0;
  localparam logic [0:0] CfgIdSeed   = 1'b1;

  localparam int StampW  = 44;
  localparam int IdW     = 48;
  localparam int HandleW = 33;

endpackage

>>> rtl/core/timestamped_history_ring_query_core.sv
// timestamped history ring with range queries: top level, depends on thrq_pkg
// an append writes its slot, reads it back and returns one acknowledge word; a query
//   searches from the oldest entry, one entry at a time through the single read
//   port, and stops at the found index r1; between runs a second search for r2
// window set and clamped, then one word per entry; an empty ring gives one empty word
// busy high throughout, one item at a time; reset clears control state only
module timestamped_history_ring_query_core #(
  parameter int HISTORY_DEPTH = 128,
  parameter int MAX_RUN       = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [47:0] cfg_data_i,
  input  logic        kind_i,
  input  logic [2:0]  query_mode_i,
  input  logic [33:0] stamp_a_secs_i,
  input  logic [9:0]  stamp_a_msec_i,
  input  logic [33:0] stamp_b_secs_i,
  input  logic [9:0]  stamp_b_msec_i,
  input  logic [7:0]  limit_i,
  input  logic        is_notice_i,
  input  logic [31:0] payload_handle_i,
  output logic        out_valid_o,
  output logic        has_entry_o,
  output logic [33:0] stamp_secs_o,
  output logic [9:0]  stamp_msec_o,
  output logic [47:0] message_id_o,
  output logic        notice_flag_o,
  output logic [31:0] handle_out_o,
  output logic        last_o
);

  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  // signed working width for window arithmetic
  localparam int SW = CW + 2;
  localparam logic [AW-1:0] LastSlot = AW'(HISTORY_DEPTH - 1);

  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StSetup  = 4'd1;
  localparam logic [3:0] StSrdA   = 4'd2;
  localparam logic [3:0] StScmpA  = 4'd3;
  localparam logic [3:0] StSrdB   = 4'd4;
  localparam logic [3:0] StScmpB  = 4'd5;
  localparam logic [3:0] StWin    = 4'd6;
  localparam logic [3:0] StClamp  = 4'd7;
  localparam logic [3:0] StRead   = 4'd8;
  localparam logic [3:0] StEmit   = 4'd9;
  localparam logic [3:0] StAppRd  = 4'd10;
  localparam logic [3:0] StAppOut = 4'd11;

  logic [thrq_pkg::StampW-1:0]  stamp_mem  [HISTORY_DEPTH];
  logic [thrq_pkg::IdW-1:0]     id_mem     [HISTORY_DEPTH];
  logic [thrq_pkg::HandleW-1:0] handle_mem [HISTORY_DEPTH];

  logic [3:0]    state_q, state_d;
  logic [AW-1:0] wpos_q;
  logic [CW-1:0] fill_q;
  logic [47:0]   idc_q;
  logic [6:0]    maxlim_q;

  logic [2:0]    mode_q;
  logic [thrq_pkg::StampW-1:0] ref_a_q, ref_b_q;
  logic [7:0]    lim_q;
  logic [CW-1:0] cnt_q;
  logic [CW-1:0] idx_q;
  logic [CW-1:0] r1_q, r2_q;
  logic signed [SW-1:0] start_q, end_q;
  logic [6:0]    n_q;
  logic [AW-1:0] base_q;
  logic [AW-1:0] app_slot_q;

  // memory port
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr, mem_raddr;
  logic [thrq_pkg::StampW-1:0]   rd_stamp;
  logic [thrq_pkg::IdW-1:0]      rd_id;
  logic [thrq_pkg::HandleW-1:0]  rd_handle;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stamp_mem[mem_waddr]  <= {stamp_a_secs_i, stamp_a_msec_i};
      id_mem[mem_waddr]     <= idc_q + 48'd1;
      handle_mem[mem_waddr] <= {is_notice_i, payload_handle_i};
    end
    rd_stamp  <= stamp_mem[mem_raddr];
    rd_id     <= id_mem[mem_raddr];
    rd_handle <= handle_mem[mem_raddr];
  end

  // slot of logical index i: base + i modulo depth
  function automatic logic [AW-1:0] slot_f(input logic [AW-1:0] b, input logic [CW-1:0] i);
    logic [AW:0] s;
    s = {1'b0, b} + (AW+1)'(i);
    if (s >= (AW+1)'(HISTORY_DEPTH)) s = s - (AW+1)'(HISTORY_DEPTH);
    return s[AW-1:0];
  endfunction

  logic accept;
  assign accept = start && !busy;
  assign busy   = (state_q != StIdle);

  logic [6:0] mx_eff;
  always_comb begin
    mx_eff = maxlim_q;
    if (mx_eff == 7'd0) mx_eff = 7'd1;
    if (mx_eff > 7'(MAX_RUN)) mx_eff = 7'(MAX_RUN);
  end

  // window computation
  logic signed [SW-1:0] s_lim, s_cnt, s_r1, s_r2, w_start, w_end, half;
  always_comb begin
    s_lim = SW'($signed({1'b0, lim_q}));
    s_cnt = SW'($signed({1'b0, cnt_q}));
    s_r1  = SW'($signed({1'b0, r1_q}));
    s_r2  = SW'($signed({1'b0, r2_q}));
    half  = s_lim >>> 1;
    w_start = '0;
    w_end   = '0;
    unique case (mode_q)
      thrq_pkg::ModeLatest: begin
        w_start = s_cnt - s_lim;
        w_end   = s_cnt;
      end
      thrq_pkg::ModeLatestAfter: begin
        w_start = s_r1 + SW'(1);
        if (s_cnt - w_start > s_lim) w_start = s_cnt - s_lim;
        w_end = s_cnt;
      end
      thrq_pkg::ModeBefore: begin
        w_end   = s_r1;
        w_start = s_r1 - s_lim;
      end
      thrq_pkg::ModeAfter: begin
        w_start = s_r1 + SW'(1);
        w_end   = s_r1 + SW'(1) + s_lim;
      end
      thrq_pkg::ModeAround: begin
        w_start = s_r1 - half;
        w_end   = w_start + s_lim;
        if (w_start < 0) begin
          w_start = '0;
          w_end   = s_lim;
        end
      end
      thrq_pkg::ModeBetween: begin
        if (s_r1 < s_r2) begin
          w_start = s_r1 + SW'(1);
          w_end   = s_r2;
        end else begin
          w_start = s_r2 + SW'(1);
          w_end   = s_r1;
        end
      end
      default: begin
        w_start = '0;
        w_end   = '0;
      end
    endcase
  end

  // second step: the end clamps and limit trims that depend on the first
  logic signed [SW-1:0] c_start, c_end;
  always_comb begin
    c_start = start_q;
    c_end   = end_q;
    if (mode_q == thrq_pkg::ModeAround) begin
      if (c_end > s_cnt) begin
        c_end   = s_cnt;
        c_start = s_cnt - s_lim;
      end
    end else if (mode_q == thrq_pkg::ModeBetween) begin
      if (c_end > s_cnt) c_end = s_cnt;
      if (c_end - c_start > s_lim) c_start = c_end - s_lim;
    end
    if (c_start < 0) c_start = '0;
    if (c_end > s_cnt) c_end = s_cnt;
  end

  logic cmp_hit_a, cmp_hit_b;
  assign cmp_hit_a = (rd_stamp >= ref_a_q);
  assign cmp_hit_b = (rd_stamp >= ref_b_q);

  logic [CW-1:0] cur_idx;
  assign cur_idx = CW'(start_q) + CW'(n_q);

  always_comb begin
    state_d   = state_q;
    mem_we    = 1'b0;
    mem_waddr = wpos_q;
    mem_raddr = slot_f(base_q, idx_q);
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (kind_i == thrq_pkg::KindAppend) begin
            mem_we  = 1'b1;
            state_d = StAppRd;
          end else begin
            state_d = StSetup;
          end
        end
      end
      StAppRd: begin
        mem_raddr = app_slot_q;
        state_d   = StAppOut;
      end
      StAppOut: state_d = StIdle;
      StSetup: begin
        if (cnt_q == '0 || mode_q > thrq_pkg::ModeBetween) state_d = StEmit;
        else state_d = StSrdA;
      end
      StSrdA: state_d = StScmpA;
      StScmpA: begin
        if (idx_q == cnt_q || cmp_hit_a) begin
          state_d = (mode_q == thrq_pkg::ModeBetween) ? StSrdB : StWin;
        end else begin
          state_d = StSrdA;
        end
      end
      StSrdB: state_d = StScmpB;
      StScmpB: begin
        if (idx_q == cnt_q || cmp_hit_b) state_d = StWin;
        else state_d = StSrdB;
      end
      StWin:   state_d = StClamp;
      StClamp: state_d = StRead;
      StRead: begin
        mem_raddr = slot_f(base_q, cur_idx);
        state_d   = StEmit;
      end
      StEmit: begin
        if (end_q > start_q + SW'($signed({1'b0, n_q})) + SW'(1) &&
            n_q + 7'd1 < 7'(lim_q)) state_d = StRead;
        else state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // idx_q during search: logical index being read; compare stage sees it
  // read data of StSrdA/StSrdB arrives in the following compare state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      wpos_q   <= '0;
      fill_q   <= '0;
      idc_q    <= '0;
      maxlim_q <= 7'd64;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          thrq_pkg::CfgMaxLimit: maxlim_q <= cfg_data_i[6:0];
          thrq_pkg::CfgIdSeed:   idc_q    <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == StIdle && accept && kind_i == thrq_pkg::KindAppend) begin
        idc_q  <= idc_q + 48'd1;
        wpos_q <= (wpos_q == LastSlot) ? '0 : wpos_q + AW'(1);
        if (fill_q < CW'(HISTORY_DEPTH)) fill_q <= fill_q + CW'(1);
      end
    end
  end

  logic [AW:0] base_sum;
  assign base_sum = {1'b0, wpos_q} + (AW+1)'(HISTORY_DEPTH) - (AW+1)'(fill_q);

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        mode_q     <= query_mode_i;
        ref_a_q    <= {stamp_a_secs_i, stamp_a_msec_i};
        ref_b_q    <= {stamp_b_secs_i, stamp_b_msec_i};
        app_slot_q <= wpos_q;
        cnt_q      <= fill_q;
        base_q     <= (base_sum >= (AW+1)'(HISTORY_DEPTH)) ?
                      AW'(base_sum - (AW+1)'(HISTORY_DEPTH)) : base_sum[AW-1:0];
        if (limit_i == 8'd0 || limit_i > {1'b0, mx_eff}) lim_q <= {1'b0, mx_eff};
        else lim_q <= limit_i;
        idx_q   <= '0;
        n_q     <= '0;
        start_q <= '0;
        end_q   <= '0;
      end
      StSrdA, StSrdB: ;
      StScmpA: begin
        if (idx_q == cnt_q || cmp_hit_a) begin
          r1_q  <= idx_q;
          idx_q <= '0;
        end else begin
          idx_q <= idx_q + CW'(1);
        end
      end
      StScmpB: begin
        if (idx_q == cnt_q || cmp_hit_b) r2_q <= idx_q;
        else idx_q <= idx_q + CW'(1);
      end
      StWin: begin
        start_q <= w_start;
        end_q   <= w_end;
      end
      StClamp: begin
        start_q <= c_start;
        end_q   <= c_end;
      end
      StEmit: n_q <= n_q + 7'd1;
      default: ;
    endcase
  end

  // empty window check happens at StClamp; an empty window emits one word with has_entry clear
  // output word register
  logic empty_win;
  assign empty_win = !(c_end > c_start);

  logic        ov_q, he_q, nf_q, last_q;
  logic [33:0] ss_q;
  logic [9:0]  sm_q;
  logic [47:0] mid_q;
  logic [31:0] ho_q;
  logic        emit_entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q         <= 1'b0;
      emit_entry_q <= 1'b0;
    end else begin
      ov_q <= 1'b0;
      if (state_q == StSetup) emit_entry_q <= 1'b0;
      if (state_q == StClamp) emit_entry_q <= !empty_win;
      if (state_q == StAppOut || state_q == StEmit) ov_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StAppOut) begin
      he_q   <= 1'b0;
      ss_q   <= rd_stamp[43:10];
      sm_q   <= rd_stamp[9:0];
      mid_q  <= rd_id;
      nf_q   <= rd_handle[32];
      ho_q   <= rd_handle[31:0];
      last_q <= 1'b1;
    end else if (state_q == StEmit) begin
      he_q   <= emit_entry_q;
      ss_q   <= emit_entry_q ? rd_stamp[43:10] : '0;
      sm_q   <= emit_entry_q ? rd_stamp[9:0] : '0;
      mid_q  <= emit_entry_q ? rd_id : '0;
      nf_q   <= emit_entry_q && rd_handle[32];
      ho_q   <= emit_entry_q ? rd_handle[31:0] : '0;
      last_q <= (state_d == StIdle);
    end
  end

  assign out_valid_o   = ov_q;
  assign has_entry_o   = he_q;
  assign stamp_secs_o  = ss_q;
  assign stamp_msec_o  = sm_q;
  assign message_id_o  = mid_q;
  assign notice_flag_o = nf_q;
  assign handle_out_o  = ho_q;
  assign last_o        = last_q;

endmodule

>>> test/tb_top.sv
// testbench for the timestamped history ring query core: directed table then random words
// predicts every result word with its own ring model; depends on thrq_pkg and the core
`timescale 1ns / 100ps

module tb_top;

  localparam int Depth = 128;
  localparam int MaxRun = 64;
  localparam int WatchLimit = 20000;

  typedef struct packed {
    logic        has_entry;
    logic [33:0] secs;
    logic [9:0]  msec;
    logic [47:0] id;
    logic        notice;
    logic [31:0] handle;
    logic        last;
  } entry_word_t;

  typedef struct {
    logic [0:0]  kind;
    logic [2:0]  mode;
    logic [33:0] a_secs;
    logic [9:0]  a_msec;
    logic [33:0] b_secs;
    logic [9:0]  b_msec;
    logic [7:0]  limit;
    logic        notice;
    logic [31:0] handle;
    bit          typed;
    entry_word_t want;
  } cmd_t;

  logic clk_i, rst_ni, start, busy, cfg_we_i, cfg_idx_i;
  logic [47:0] cfg_data_i;
  logic kind_i, is_notice_i;
  logic [2:0] query_mode_i;
  logic [33:0] stamp_a_secs_i, stamp_b_secs_i;
  logic [9:0] stamp_a_msec_i, stamp_b_msec_i;
  logic [7:0] limit_i;
  logic [31:0] payload_handle_i;
  logic out_valid_o, has_entry_o, notice_flag_o, last_o;
  logic [33:0] stamp_secs_o;
  logic [9:0] stamp_msec_o;
  logic [47:0] message_id_o;
  logic [31:0] handle_out_o;

  timestamped_history_ring_query_core u_top (.*);

  // ring copy
  logic [43:0] ring_stamp[Depth];
  logic [47:0] ring_id[Depth];
  logic [32:0] ring_handle[Depth];
  int unsigned wr_pos, fill;
  logic [47:0] id_count;
  logic [6:0] max_limit_reg;

  entry_word_t expected_words[$];
  int mismatches, accepted_cycles_idle;
  int sender_idle_pct;
  cmd_t directed[$];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int ring_slot(int i);
    return (wr_pos + Depth - fill + i) % Depth;
  endfunction

  function automatic int first_at_or_after(logic [43:0] stamp_ref);
    for (int i = 0; i < fill; i++)
      if (ring_stamp[ring_slot(i)] >= stamp_ref) return i;
    return fill;
  endfunction

  function automatic entry_word_t word_at(int slot, logic has);
    entry_word_t w;
    w.has_entry = has;
    w.secs = ring_stamp[slot][43:10];
    w.msec = ring_stamp[slot][9:0];
    w.id = ring_id[slot];
    w.notice = ring_handle[slot][32];
    w.handle = ring_handle[slot][31:0];
    w.last = 1'b0;
    return w;
  endfunction

  task automatic predict_words(input cmd_t c);
    int cnt, lim, mx, lo, hi, r1, r2, n, slot;
    entry_word_t w;
    cnt = fill;
    if (c.kind == thrq_pkg::KindAppend) begin
      slot = wr_pos;
      id_count = id_count + 48'd1;
      ring_stamp[slot] = {c.a_secs, c.a_msec};
      ring_id[slot] = id_count;
      ring_handle[slot] = {c.notice, c.handle};
      wr_pos = (slot + 1) % Depth;
      if (fill < Depth) fill++;
      w = word_at(slot, 1'b0);
      w.last = 1'b1;
      expected_words.push_back(w);
      return;
    end
    mx = max_limit_reg;
    if (mx < 1) mx = 1;
    if (mx > MaxRun) mx = MaxRun;
    lim = c.limit;
    if (lim == 0 || lim > mx) lim = mx;
    lo = 0;
    hi = 0;
    if (cnt > 0 && c.mode <= thrq_pkg::ModeBetween) begin
      r1 = first_at_or_after({c.a_secs, c.a_msec});
      case (c.mode)
        thrq_pkg::ModeLatest: begin
          lo = cnt - lim; hi = cnt;
        end
        thrq_pkg::ModeLatestAfter: begin
          lo = r1 + 1;
          if (cnt - lo > lim) lo = cnt - lim;
          hi = cnt;
        end
        thrq_pkg::ModeBefore: begin
          hi = r1; lo = hi - lim;
        end
        thrq_pkg::ModeAfter: begin
          lo = r1 + 1; hi = lo + lim;
        end
        thrq_pkg::ModeAround: begin
          lo = r1 - lim / 2;
          hi = lo + lim;
          if (lo < 0) begin lo = 0; hi = lim; end
          if (hi > cnt) begin hi = cnt; lo = hi - lim; end
        end
        default: begin
          r2 = first_at_or_after({c.b_secs, c.b_msec});
          if (r1 < r2) begin lo = r1 + 1; hi = r2; end
          else begin lo = r2 + 1; hi = r1; end
          if (lo < 0) lo = 0;
          if (hi > cnt) hi = cnt;
          if (hi - lo > lim) lo = hi - lim;
        end
      endcase
      if (lo < 0) lo = 0;
      if (hi > cnt) hi = cnt;
    end
    n = 0;
    for (int i = lo; i < hi && n < lim; i++) begin
      w = word_at(ring_slot(i), 1'b1);
      w.last = (i + 1 >= hi) || (n + 1 >= lim);
      expected_words.push_back(w);
      n++;
    end
    if (n == 0) expected_words.push_back('{last: 1'b1, default: '0});
  endtask

  // result checking
  always @(posedge clk_i) begin
    entry_word_t got, want;
    if (rst_ni && out_valid_o) begin
      got = '{has_entry_o, stamp_secs_o, stamp_msec_o, message_id_o, notice_flag_o,
              handle_out_o, last_o};
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", got);
      end else begin
        want = expected_words.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %h actual %h", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || out_valid_o) accepted_cycles_idle <= 0;
    else accepted_cycles_idle <= accepted_cycles_idle + 1;
    if (accepted_cycles_idle >= WatchLimit) begin
      $display("FAIL timestamped_history_ring_query_core");
      $finish;
    end
  end

  // the caller drops the write enable after the last write
  task automatic write_reg(input logic idx, input logic [47:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == thrq_pkg::CfgMaxLimit) max_limit_reg = val[6:0];
    else id_count = val;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  // holds the word until accepted, with random gaps beforehand
  task automatic issue(input cmd_t c);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    start <= 1'b1;
    kind_i <= c.kind;
    query_mode_i <= c.mode;
    stamp_a_secs_i <= c.a_secs;
    stamp_a_msec_i <= c.a_msec;
    stamp_b_secs_i <= c.b_secs;
    stamp_b_msec_i <= c.b_msec;
    limit_i <= c.limit;
    is_notice_i <= c.notice;
    payload_handle_i <= c.handle;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_words(c);
    if (c.typed && expected_words.size() != 0 && expected_words[$] !== c.want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row: expected %h predicted %h", c.want, expected_words[$]);
    end
  endtask

  function automatic cmd_t mk(logic [0:0] k, logic [2:0] m, logic [33:0] as, logic [9:0] am,
                              logic [33:0] bs, logic [9:0] bm, logic [7:0] lim,
                              logic nt, logic [31:0] h);
    cmd_t c;
    c = '{kind: k, mode: m, a_secs: as, a_msec: am, b_secs: bs, b_msec: bm, limit: lim,
          notice: nt, handle: h, typed: 1'b0, want: '0};
    return c;
  endfunction

  // random stamps near a base so references land inside the ring
  function automatic cmd_t rand_cmd(logic [33:0] base);
    cmd_t c;
    c = mk($urandom_range(99) < 45 ? thrq_pkg::KindAppend : thrq_pkg::KindQuery,
           3'($urandom_range(99) < 95 ? $urandom_range(5) : $urandom_range(7, 6)),
           base + $urandom_range(60),
           10'($urandom_range(99) < 90 ? $urandom_range(999) : $urandom_range(1023)),
           base + $urandom_range(60), 10'($urandom_range(1023)),
           8'($urandom_range(99) < 70 ? $urandom_range(12) : $urandom_range(255)),
           1'($urandom_range(1)), $urandom);
    if ($urandom_range(99) < 5) begin
      c.a_secs = {2'($urandom_range(3)), $urandom};
      c.b_secs = {2'($urandom_range(3)), $urandom};
    end
    return c;
  endfunction

  initial begin
    cmd_t c;
    logic [33:0] base;
    mismatches = 0;
    accepted_cycles_idle = 0;
    sender_idle_pct = 0;
    start = 1'b0; cfg_we_i = 1'b0; cfg_idx_i = 1'b0; cfg_data_i = '0;
    kind_i = 1'b0; query_mode_i = '0; stamp_a_secs_i = '0; stamp_a_msec_i = '0;
    stamp_b_secs_i = '0; stamp_b_msec_i = '0; limit_i = '0; is_notice_i = 1'b0;
    payload_handle_i = '0;
    fill = 0; wr_pos = 0; id_count = '0; max_limit_reg = 7'd64;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty ring query gives the empty marker
    c = mk(thrq_pkg::KindQuery, thrq_pkg::ModeLatest, '0, '0, '0, '0, '0, 1'b0, '0);
    c.typed = 1'b1; c.want = '{last: 1'b1, default: '0};
    directed.push_back(c);
    c = mk(thrq_pkg::KindAppend, thrq_pkg::ModeLatest, '1, 10'd999, '0, '0, '0, 1'b1, '1);
    c.typed = 1'b1; c.want = '{1'b0, '1, 10'd999, 48'd1, 1'b1, '1, 1'b1};
    directed.push_back(c);
    directed.push_back(mk(thrq_pkg::KindAppend, thrq_pkg::ModeLatest, '0, '0, '0, '0, '0,
                          1'b0, '0));
    directed.push_back(mk(thrq_pkg::KindAppend, thrq_pkg::ModeLatest, 34'd5, 10'd1023, '0, '0,
                          '0, 1'b0, 32'h1234));
    directed.push_back(mk(thrq_pkg::KindAppend, thrq_pkg::ModeLatest, 34'd9, 10'd1, '0, '0,
                          '0, 1'b1, 32'hbeef));
    directed.push_back(mk(thrq_pkg::KindAppend, thrq_pkg::ModeLatest, 34'd9, 10'd1, '0, '0,
                          '0, 1'b0, 32'h55aa));
    for (int m = 0; m < 6; m++) begin
      directed.push_back(mk(thrq_pkg::KindQuery, 3'(m), 34'd5, 10'd0, 34'd9, 10'd1, 8'd0,
                            1'b0, '0));
      directed.push_back(mk(thrq_pkg::KindQuery, 3'(m), 34'd9, 10'd1, 34'd0, 10'd0, 8'd2,
                            1'b0, '0));
    end
    directed.push_back(mk(thrq_pkg::KindQuery, thrq_pkg::ModeBetween, '1, '1, '0, '0, 8'd255,
                          1'b0, '0));
    c = mk(thrq_pkg::KindQuery, 3'd7, '0, '0, '0, '0, '0, 1'b0, '0);
    c.typed = 1'b1; c.want = '{last: 1'b1, default: '0};
    directed.push_back(c);
    directed.push_back(mk(thrq_pkg::KindQuery, 3'd6, '1, '1, '1, '1, '1, 1'b1, '1));
    foreach (directed[i]) issue(directed[i]);
    wait_idle();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 8;
          write_reg(thrq_pkg::CfgMaxLimit, 48'd1);
          write_reg(thrq_pkg::CfgIdSeed, 48'hffff_ffff_fffe);
        end
        1: begin
          sender_idle_pct = 80;
          write_reg(thrq_pkg::CfgMaxLimit, 48'd0);
          write_reg(thrq_pkg::CfgIdSeed, 48'd0);
        end
        default: begin
          sender_idle_pct = 0;
          write_reg(thrq_pkg::CfgMaxLimit, 48'd127);
          write_reg(thrq_pkg::CfgIdSeed, 48'({$urandom, $urandom}));
        end
      endcase
      cfg_we_i <= 1'b0;
      base = $urandom_range(99) < 50 ? 34'd0 : {2'($urandom_range(3)), $urandom};
      for (int i = 0; i < 50; i++) begin
        c = rand_cmd(base);
        if (c.kind == thrq_pkg::KindAppend) base = base + $urandom_range(1);
        issue(c);
      end
      wait_idle();
    end
    write_reg(thrq_pkg::CfgMaxLimit, 48'd64);
    cfg_we_i <= 1'b0;
    for (int i = 0; i < 140; i++) issue(mk(thrq_pkg::KindAppend, thrq_pkg::ModeLatest,
                                          34'd100 + i, '0, '0, '0, '0, 1'b0, i));
    issue(mk(thrq_pkg::KindQuery, thrq_pkg::ModeLatest, '0, '0, '0, '0, '0, 1'b0, '0));
    issue(mk(thrq_pkg::KindQuery, thrq_pkg::ModeAround, 34'd150, '0, '0, '0, '0, 1'b0, '0));
    wait_idle();

    if (mismatches == 0 && expected_words.size() == 0)
      $display("PASS timestamped_history_ring_query_core");
    else
      $display("FAIL timestamped_history_ring_query_core");
    $finish;
  end

endmodule
